FILE: hw/rtl/ipt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ipt_pkg;

	localparam int unsigned DEF_CAPACITY      = 64;
	localparam int unsigned DEF_PAYLOAD_BITS  = 32;
	localparam int unsigned DEF_PRIORITY_BITS = 16;

	typedef enum logic [2:0] {
		CMD_ADD      = 3'd0,
		CMD_PROMOTE  = 3'd1,
		CMD_IS_VALID = 3'd2,
		CMD_GET      = 3'd3,
		CMD_GET_MAX  = 3'd4,
		CMD_POP_MAX  = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_BAD_ID = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ipt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module ipt_ram #(
	parameter int unsigned DEPTH  = ipt_pkg::DEF_CAPACITY,
	parameter int unsigned ADDR_W = $clog2(ipt_pkg::DEF_CAPACITY),
	parameter int unsigned DATA_W = 1 + ipt_pkg::DEF_PRIORITY_BITS + ipt_pkg::DEF_PAYLOAD_BITS
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/indexed_priority_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Add, unused commands and ids at or above the entry count go straight to the finish state.
// Promote, is-valid, get: one entry-memory read, then write-back in the look state.
// Get-max and pop-max scan the entries (an empty table goes straight to the finish state),
// reading one entry per cycle through the single memory read port.
// One transaction in flight; a new command is taken while the previous response waits.
// Reset clears count, control and response valid; memory is not cleared, entries at or above
// the count are never treated as live.

module indexed_priority_table_unit #(
	parameter int unsigned CAPACITY      = ipt_pkg::DEF_CAPACITY,
	parameter int unsigned PAYLOAD_BITS  = ipt_pkg::DEF_PAYLOAD_BITS,
	parameter int unsigned PRIORITY_BITS = ipt_pkg::DEF_PRIORITY_BITS,
	localparam int unsigned ID_W         = $clog2(CAPACITY)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cmd_valid,
	output logic                          cmd_stall,
	input  wire logic [2:0]               command,
	input  wire logic [ID_W-1:0]          entry_id,
	input  wire logic [PAYLOAD_BITS-1:0]  payload,
	output logic                          rsp_valid,
	input  wire logic                     rsp_stall,
	output logic [ID_W-1:0]               result_id,
	output logic [PAYLOAD_BITS-1:0]       result_payload,
	output logic [PRIORITY_BITS-1:0]      result_priority,
	output logic                          is_live,
	output logic [1:0]                    status
);

	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned DATA_W = 1 + PRIORITY_BITS + PAYLOAD_BITS;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_SCAN = 4'b0100,
		S_FIN  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [CNT_W-1:0]         count_q;
	logic [2:0]               cmd_q;
	logic [ID_W-1:0]          id_q;
	logic [CNT_W-1:0]         scan_addr_q;
	logic                     rd_vld_s1;
	logic [ID_W-1:0]          rd_idx_s1;
	logic                     found_q;
	logic [ID_W-1:0]          best_id_q;
	logic [PRIORITY_BITS-1:0] best_pri_q;
	logic [PAYLOAD_BITS-1:0]  best_pay_q;

	logic [ID_W-1:0]          res_id_q;
	logic [PAYLOAD_BITS-1:0]  res_pay_q;
	logic [PRIORITY_BITS-1:0] res_pri_q;
	logic                     res_live_q;
	logic [1:0]               res_status_q;

	logic                     ram_we;
	logic [ID_W-1:0]          ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic                     ram_re;
	logic [ID_W-1:0]          ram_raddr;
	logic [DATA_W-1:0]        ram_rdata;

	logic                     accept;
	logic                     full;
	logic                     rd_live;
	logic [PRIORITY_BITS-1:0] rd_pri;
	logic [PAYLOAD_BITS-1:0]  rd_pay;
	logic [PRIORITY_BITS-1:0] pri_inc;
	logic                     scan_issue;
	logic                     scan_last;
	logic                     hit;
	logic                     fin_found;
	logic [ID_W-1:0]          fin_id;
	logic [PRIORITY_BITS-1:0] fin_pri;
	logic [PAYLOAD_BITS-1:0]  fin_pay;
	logic                     rsp_load;

	state_t                   acc_state;
	logic                     acc_add;
	logic [ID_W-1:0]          acc_id;
	logic [1:0]               acc_status;

	ipt_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (ID_W),
		.DATA_W (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign cmd_stall = (state_q != S_IDLE);
	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign full      = (count_q >= CNT_W'(CAPACITY));
	assign rsp_load  = (state_q == S_FIN) && (!rsp_valid || !rsp_stall);

	assign rd_live = ram_rdata[DATA_W-1];
	assign rd_pri  = ram_rdata[PAYLOAD_BITS +: PRIORITY_BITS];
	assign rd_pay  = ram_rdata[PAYLOAD_BITS-1:0];
	assign pri_inc = (&rd_pri) ? rd_pri : rd_pri + PRIORITY_BITS'(1);

	assign scan_issue = (state_q == S_SCAN) && (scan_addr_q < count_q);
	assign scan_last  = rd_vld_s1 && (CNT_W'(rd_idx_s1) == count_q - CNT_W'(1));
	// later entries win ties
	assign hit        = rd_vld_s1 && rd_live && (!found_q || rd_pri >= best_pri_q);
	assign fin_found  = found_q || hit;
	assign fin_id     = hit ? rd_idx_s1 : best_id_q;
	assign fin_pri    = hit ? rd_pri : best_pri_q;
	assign fin_pay    = hit ? rd_pay : best_pay_q;

	// decode of an accepted command
	always_comb begin
		acc_state  = S_FIN;
		acc_add    = 1'b0;
		acc_id     = '0;
		acc_status = ipt_pkg::ST_OK;
		unique case (command)
			ipt_pkg::CMD_ADD: begin
				if (full) begin
					acc_status = ipt_pkg::ST_FULL;
				end else begin
					acc_add = 1'b1;
					acc_id  = count_q[ID_W-1:0];
				end
			end
			ipt_pkg::CMD_PROMOTE, ipt_pkg::CMD_IS_VALID, ipt_pkg::CMD_GET: begin
				acc_id = entry_id;
				if (CNT_W'(entry_id) >= count_q) begin
					if (command != ipt_pkg::CMD_IS_VALID) begin
						acc_status = ipt_pkg::ST_BAD_ID;
					end
				end else begin
					acc_state = S_LOOK;
				end
			end
			ipt_pkg::CMD_GET_MAX, ipt_pkg::CMD_POP_MAX: begin
				if (count_q == '0) begin
					acc_status = ipt_pkg::ST_EMPTY;
				end else begin
					acc_state = S_SCAN;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (command)
						ipt_pkg::CMD_ADD: begin
							if (!full) begin
								ram_we    = 1'b1;
								ram_waddr = count_q[ID_W-1:0];
								ram_wdata = {1'b1, {PRIORITY_BITS{1'b0}}, payload};
							end
						end
						ipt_pkg::CMD_PROMOTE, ipt_pkg::CMD_IS_VALID, ipt_pkg::CMD_GET: begin
							ram_re    = 1'b1;
							ram_raddr = entry_id;
						end
						default: begin
						end
					endcase
				end
			end
			S_LOOK: begin
				if (cmd_q == ipt_pkg::CMD_PROMOTE && rd_live) begin
					ram_we    = 1'b1;
					ram_waddr = id_q;
					ram_wdata = {1'b1, pri_inc, rd_pay};
				end
			end
			S_SCAN: begin
				ram_re    = scan_issue;
				ram_raddr = scan_addr_q[ID_W-1:0];
				if (scan_last && fin_found && cmd_q == ipt_pkg::CMD_POP_MAX) begin
					ram_we    = 1'b1;
					ram_waddr = fin_id;
					ram_wdata = {1'b0, fin_pri, fin_pay};
				end
			end
			S_FIN: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			count_q         <= '0;
			cmd_q           <= '0;
			id_q            <= '0;
			scan_addr_q     <= '0;
			rd_vld_s1       <= 1'b0;
			rd_idx_s1       <= '0;
			found_q         <= 1'b0;
			best_id_q       <= '0;
			best_pri_q      <= '0;
			best_pay_q      <= '0;
			res_id_q        <= '0;
			res_pay_q       <= '0;
			res_pri_q       <= '0;
			res_live_q      <= 1'b0;
			res_status_q    <= ipt_pkg::ST_OK;
			rsp_valid       <= 1'b0;
			result_id       <= '0;
			result_payload  <= '0;
			result_priority <= '0;
			is_live         <= 1'b0;
			status          <= ipt_pkg::ST_OK;
		end else begin
			rd_vld_s1 <= scan_issue;
			rd_idx_s1 <= scan_addr_q[ID_W-1:0];
			if (rsp_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q        <= command;
						id_q         <= entry_id;
						found_q      <= 1'b0;
						scan_addr_q  <= '0;
						state_q      <= acc_state;
						res_id_q     <= acc_id;
						res_pay_q    <= acc_add ? payload : '0;
						res_pri_q    <= '0;
						res_live_q   <= acc_add;
						res_status_q <= acc_status;
						if (acc_add) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				S_LOOK: begin
					state_q <= S_FIN;
					if (rd_live) begin
						res_pay_q  <= rd_pay;
						res_pri_q  <= (cmd_q == ipt_pkg::CMD_PROMOTE) ? pri_inc : rd_pri;
						res_live_q <= 1'b1;
					end else if (cmd_q != ipt_pkg::CMD_IS_VALID) begin
						res_status_q <= ipt_pkg::ST_BAD_ID;
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						scan_addr_q <= scan_addr_q + CNT_W'(1);
					end
					if (hit) begin
						found_q    <= 1'b1;
						best_id_q  <= rd_idx_s1;
						best_pri_q <= rd_pri;
						best_pay_q <= rd_pay;
					end
					if (scan_last) begin
						state_q <= S_FIN;
						if (fin_found) begin
							res_id_q   <= fin_id;
							res_pay_q  <= fin_pay;
							res_pri_q  <= fin_pri;
							res_live_q <= 1'b1;
						end else begin
							res_status_q <= ipt_pkg::ST_EMPTY;
						end
					end
				end
				S_FIN: begin
					if (rsp_load) begin
						result_id       <= res_id_q;
						result_payload  <= res_pay_q;
						result_priority <= res_pri_q;
						is_live         <= res_live_q;
						status          <= res_status_q;
						state_q         <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count moved by more than one");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (CNT_W'(rd_idx_s1) < count_q))
		else $error("scan read beyond entry count");

	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q == S_IDLE) |-> (accept && command == ipt_pkg::CMD_ADD && !full))
		else $error("memory write in idle without add");

	a_empty_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ipt_pkg::ST_EMPTY) |-> (!is_live && result_priority == '0))
		else $error("empty response carries an entry");

endmodule

`default_nettype wire

FILE: tb/indexed_priority_table_unit_tb.sv
`timescale 1ns / 1ps

module indexed_priority_table_unit_tb;
	import ipt_pkg::*;

	localparam int unsigned NUM_ENTRIES = DEF_CAPACITY;
	localparam int unsigned ID_BITS = $clog2(NUM_ENTRIES);
	localparam logic [DEF_PRIORITY_BITS-1:0] PRIO_MAX = '1;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int unsigned RANDOM_ITEMS = 1750;
	localparam int unsigned RUN_PROMOTES = 40;
	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_CYCLES = 100;
	localparam int unsigned MAX_REPORTS = 60;
	localparam int unsigned TIMEOUT_NS = 40_000_000;

	typedef struct {
		logic [ID_BITS-1:0]           id;
		logic [DEF_PAYLOAD_BITS-1:0]  pl;
		logic [DEF_PRIORITY_BITS-1:0] pri;
		logic                         live;
		status_t                      st;
	} table_rsp_t;

	class table_scoreboard;
		logic [DEF_PAYLOAD_BITS-1:0]  payload_mem [NUM_ENTRIES];
		logic [DEF_PRIORITY_BITS-1:0] prio_mem [NUM_ENTRIES];
		bit                           live_mem [NUM_ENTRIES];
		int unsigned                  entry_count;
		table_rsp_t                   expected_rsps [$];
		int unsigned                  errors;
		int unsigned                  checked;
		int unsigned                  reports;
		int unsigned                  status_seen [4];
		int unsigned                  peak_pri;

		function new();
			entry_count = 0;
			errors = 0;
			checked = 0;
			reports = 0;
			peak_pri = 0;
			foreach (live_mem[i]) begin
				live_mem[i] = 1'b0;
				payload_mem[i] = '0;
				prio_mem[i] = '0;
			end
			foreach (status_seen[i]) begin
				status_seen[i] = 0;
			end
		endfunction

		function bit id_live(int unsigned id);
			return id < entry_count && live_mem[id];
		endfunction

		function table_rsp_t entry_rsp(int unsigned slot);
			table_rsp_t r;
			r.id = slot[ID_BITS-1:0];
			r.pl = payload_mem[slot];
			r.pri = prio_mem[slot];
			r.live = 1'b1;
			r.st = ST_OK;
			return r;
		endfunction

		// Updates the table copy and queues the response the command should produce.
		function void note_command(logic [2:0] cmd, logic [ID_BITS-1:0] id,
				logic [DEF_PAYLOAD_BITS-1:0] data);
			table_rsp_t r;
			int unsigned slot;
			int unsigned best_pri;
			r.id = '0;
			r.pl = '0;
			r.pri = '0;
			r.live = 1'b0;
			r.st = ST_OK;
			case (cmd)
			CMD_ADD: begin
				if (entry_count >= NUM_ENTRIES) begin
					r.st = ST_FULL;
				end else begin
					slot = entry_count;
					payload_mem[slot] = data;
					prio_mem[slot] = '0;
					live_mem[slot] = 1'b1;
					entry_count++;
					r = entry_rsp(slot);
				end
			end
			CMD_PROMOTE, CMD_GET: begin
				r.id = id;
				if (!id_live(32'(id))) begin
					r.st = ST_BAD_ID;
				end else begin
					if (cmd == CMD_PROMOTE && prio_mem[id] != PRIO_MAX)
						prio_mem[id]++;
					r = entry_rsp(32'(id));
				end
			end
			CMD_IS_VALID: begin
				r.id = id;
				if (id_live(32'(id)))
					r = entry_rsp(32'(id));
			end
			CMD_GET_MAX, CMD_POP_MAX: begin
				// newest entry wins ties
				slot = NUM_ENTRIES;
				best_pri = 0;
				for (int unsigned i = 0; i < entry_count; i++) begin
					if (live_mem[i] && (slot == NUM_ENTRIES || 32'(prio_mem[i]) >= best_pri)) begin
						slot = i;
						best_pri = 32'(prio_mem[i]);
					end
				end
				if (slot == NUM_ENTRIES) begin
					r.st = ST_EMPTY;
				end else begin
					r = entry_rsp(slot);
					if (cmd == CMD_POP_MAX)
						live_mem[slot] = 1'b0;
				end
			end
			default: begin
			end
			endcase
			expected_rsps = {expected_rsps, r};
		endfunction

		function void field_check(string what, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("%0t: %s mismatch, expected %0h, actual %0h",
						$time, what, exp_v, act_v);
				end
			end
		endfunction

		function void check_response(logic [ID_BITS-1:0] id, logic [DEF_PAYLOAD_BITS-1:0] pl,
				logic [DEF_PRIORITY_BITS-1:0] pri, logic live, logic [1:0] st);
			table_rsp_t e;
			checked++;
			if (expected_rsps.size() == 0) begin
				errors++;
				if (reports < MAX_REPORTS) begin
					reports++;
					$display("%0t: response with none pending, expected nothing, actual id %0h status %0d",
						$time, id, st);
				end
				return;
			end
			e = expected_rsps.pop_front();
			status_seen[e.st]++;
			if (e.live && 32'(e.pri) > peak_pri)
				peak_pri = 32'(e.pri);
			field_check("result_id", 64'(e.id), 64'(id));
			field_check("result_payload", 64'(e.pl), 64'(pl));
			field_check("result_priority", 64'(e.pri), 64'(pri));
			field_check("is_live", 64'(e.live), 64'(live));
			field_check("status", 64'(e.st), 64'(st));
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          cmd_valid;
	logic                          cmd_stall;
	logic [2:0]                    command;
	logic [ID_BITS-1:0]            entry_id;
	logic [DEF_PAYLOAD_BITS-1:0]   payload;
	logic                          rsp_valid;
	logic                          rsp_stall;
	logic [ID_BITS-1:0]            result_id;
	logic [DEF_PAYLOAD_BITS-1:0]   result_payload;
	logic [DEF_PRIORITY_BITS-1:0]  result_priority;
	logic                          is_live;
	logic [1:0]                    status;

	bit hold_req = 1'b0;
	bit rx_quiet = 1'b0;
	table_scoreboard sb = new();

	indexed_priority_table_unit u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_stall       (cmd_stall),
		.command         (command),
		.entry_id        (entry_id),
		.payload         (payload),
		.rsp_valid       (rsp_valid),
		.rsp_stall       (rsp_stall),
		.result_id       (result_id),
		.result_payload  (result_payload),
		.result_priority (result_priority),
		.is_live         (is_live),
		.status          (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int unsigned gap_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 50);
		return $urandom_range(1, 3);
	endfunction

	// mostly ids below the count, sometimes anything
	function automatic logic [ID_BITS-1:0] pick_id();
		if (sb.entry_count > 0 && $urandom_range(0, 3) != 0)
			return ID_BITS'($urandom_range(0, sb.entry_count - 1));
		return ID_BITS'($urandom_range(0, NUM_ENTRIES - 1));
	endfunction

	task automatic send_command(input logic [2:0] cmd, input logic [ID_BITS-1:0] id,
			input logic [DEF_PAYLOAD_BITS-1:0] data);
		cmd_valid <= 1'b1;
		command <= cmd;
		entry_id <= id;
		payload <= data;
		do @(posedge clk); while (cmd_stall);
		sb.note_command(cmd, id, data);
	endtask

	task automatic pause_sender(input int unsigned cycles);
		cmd_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// response side: random stalls, calm stretches, one long hold-off on request
	initial begin
		int unsigned stall_left;
		int unsigned calm_left;
		stall_left = 0;
		calm_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && !rsp_stall)
				sb.check_response(result_id, result_payload, result_priority, is_live, status);
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end else if (rx_quiet) begin
				stall_left = 0;
			end else if (stall_left == 0) begin
				if (calm_left > 0)
					calm_left--;
				else if ($urandom_range(0, 199) == 0)
					calm_left = $urandom_range(50, 300);
				else if ($urandom_range(0, 3) == 0)
					stall_left = gap_len();
			end
			if (stall_left > 0) begin
				rsp_stall <= 1'b1;
				stall_left--;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned pick;
		int unsigned pop_w;
		int unsigned calm_tx;
		calm_tx = 0;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		command <= CMD_ADD;
		entry_id <= '0;
		payload <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, bad ids, ties, promote, pop and retired ids
		send_command(CMD_GET_MAX, '0, '0);
		send_command(CMD_POP_MAX, '1, '1);
		send_command(CMD_GET, '0, '0);
		send_command(CMD_PROMOTE, '1, '0);
		send_command(CMD_IS_VALID, '0, '0);
		send_command(CMD_ADD, '0, '0);
		send_command(CMD_ADD, '1, '1);
		send_command(CMD_ADD, '0, 32'hA5A5_5A5A);
		send_command(CMD_GET_MAX, '0, '0);
		send_command(CMD_PROMOTE, ID_BITS'(0), '0);
		send_command(CMD_PROMOTE, ID_BITS'(0), '0);
		send_command(CMD_PROMOTE, ID_BITS'(1), '0);
		send_command(CMD_GET_MAX, '0, '0);
		send_command(CMD_IS_VALID, ID_BITS'(1), '0);
		send_command(CMD_GET, ID_BITS'(2), '0);
		send_command(CMD_POP_MAX, '0, '0);
		send_command(CMD_IS_VALID, ID_BITS'(0), '0);
		send_command(CMD_PROMOTE, ID_BITS'(0), '0);
		send_command(CMD_GET, ID_BITS'(0), '0);
		send_command(CMD_SPARE_6, '1, '1);
		send_command(CMD_SPARE_7, '0, '0);
		send_command(CMD_PROMOTE, ID_BITS'(1), '0);
		send_command(CMD_GET_MAX, '0, '0);
		send_command(CMD_IS_VALID, '1, '0);

		// walk one entry's priority up back to back, then pop it
		rx_quiet = 1'b1;
		for (int unsigned k = 0; k < RUN_PROMOTES; k++)
			send_command(CMD_PROMOTE, ID_BITS'(1), $urandom());
		send_command(CMD_POP_MAX, '0, '0);
		rx_quiet = 1'b0;

		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS / 3)
				hold_req = 1'b1;
			if (calm_tx > 0)
				calm_tx--;
			else if ($urandom_range(0, 99) < 3)
				calm_tx = $urandom_range(20, 120);
			else if ($urandom_range(0, 2) == 0)
				pause_sender(gap_len());
			// drain the table harder in the last third
			pop_w = (n < 2 * RANDOM_ITEMS / 3) ? 4 : 12;
			pick = $urandom_range(0, 99);
			if (pick < 7)
				send_command(CMD_ADD, pick_id(), $urandom());
			else if (pick < 40)
				send_command(CMD_PROMOTE, pick_id(), $urandom());
			else if (pick < 54)
				send_command(CMD_IS_VALID, pick_id(), $urandom());
			else if (pick < 68)
				send_command(CMD_GET, pick_id(), $urandom());
			else if (pick < 96 - pop_w)
				send_command(CMD_GET_MAX, pick_id(), $urandom());
			else if (pick < 96)
				send_command(CMD_POP_MAX, pick_id(), $urandom());
			else if (pick < 98)
				send_command(CMD_SPARE_6, pick_id(), $urandom());
			else
				send_command(CMD_SPARE_7, pick_id(), $urandom());
		end
		cmd_valid <= 1'b0;

		while (sb.expected_rsps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d responses: %0d ok, %0d table full, %0d bad id, %0d empty table.",
			sb.checked, sb.status_seen[ST_OK], sb.status_seen[ST_FULL],
			sb.status_seen[ST_BAD_ID], sb.status_seen[ST_EMPTY]);
		$display("%0d entries added, highest priority reported %0d, %0d errors.",
			sb.entry_count, sb.peak_pri, sb.errors);
		if (sb.errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
